[sv/i2cam_pkg.sv]
// package for the auto-mode i2c master: beat structs, sequencer step codes,
// bus operation codes and register offsets
// no dependencies
package i2cam_pkg;

  typedef struct packed {
    logic        cmd;
    logic [11:0] offset;
    logic [31:0] wdata;
    logic        write_start_refused;
    logic        read_start_refused;
    logic [7:0]  recv_first;
    logic [7:0]  recv_second;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  bus_op;
    logic [6:0]  bus_slave;
    logic [7:0]  bus_byte;
    logic [31:0] read_data;
    logic        irq;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_START_W = 3'd0,
    OP_SEND    = 3'd1,
    OP_END     = 3'd2,
    OP_START_R = 3'd3,
    OP_RECV    = 3'd4
  } bus_op_e;

  typedef enum logic [3:0] {
    STEP_START_W,
    STEP_ADDR_LO,
    STEP_ADDR_HI,
    STEP_END,
    STEP_START_R,
    STEP_RECV_HI,
    STEP_RECV_LO,
    STEP_DATA_LO,
    STEP_DATA_HI,
    STEP_RESP
  } step_e;

  typedef struct packed {
    logic  accept;
    logic  fire;
    step_e step;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic xfer;
    logic is_read;
    logic addr16;
    logic data16;
    logic wr_refused;
    logic rd_refused;
  } dp_sts_t;

  localparam logic        CMD_READ  = 1'b0;
  localparam logic        CMD_WRITE = 1'b1;
  localparam logic        KIND_RESP = 1'b0;
  localparam logic        KIND_BUS  = 1'b1;

  localparam logic [11:0] OFF_CTRL     = 12'h000;
  localparam logic [11:0] OFF_TAR      = 12'h004;
  localparam logic [11:0] OFF_SCL_HI   = 12'h01C;
  localparam logic [11:0] OFF_SCL_LO   = 12'h020;
  localparam logic [11:0] OFF_INTR_ST  = 12'h02C;
  localparam logic [11:0] OFF_INTR_MSK = 12'h030;
  localparam logic [11:0] OFF_RAW_ST   = 12'h034;
  localparam logic [11:0] OFF_RX_TL    = 12'h038;
  localparam logic [11:0] OFF_TX_TL    = 12'h03C;
  localparam logic [11:0] OFF_CLR_INTR = 12'h040;
  localparam logic [11:0] OFF_ENABLE   = 12'h06C;
  localparam logic [11:0] OFF_RXFLR    = 12'h078;
  localparam logic [11:0] OFF_SDA_HOLD = 12'h07C;
  localparam logic [11:0] OFF_EN_ST    = 12'h09C;
  localparam logic [11:0] OFF_LOCK     = 12'h0AC;
  localparam logic [11:0] OFF_AUTO     = 12'h0B0;
  localparam logic [11:0] OFF_XFER     = 12'h0B4;

  localparam logic [31:0] UNLOCK_KEY     = 32'h1ACC_E551;
  localparam logic [31:0] AUTO_RESET     = 32'h0F00_0000;
  localparam logic [7:0]  AUTO_OFF_TOP   = 8'h0F;
  localparam logic [31:0] AUTO_RD_BITS   = 32'h0030_0000;
  localparam logic [15:0] RX_REFUSED     = 16'hFFFF;
  localparam int          ABORT_BIT      = 6;
  localparam int          AUTO_ABORT_BIT = 23;
  localparam int          AUTO_RXV_BIT   = 8;

endpackage

[sv/i2cam_ctrl.sv]
// sequencer for the auto-mode i2c master: walks one register access through
// its bus operation beats and final response
// depends on i2cam_pkg
module i2cam_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  i2cam_pkg::dp_sts_t  sts_i,
  output i2cam_pkg::dp_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_START_W = 4'd2;
  localparam logic [3:0] S_ADDR_LO = 4'd3;
  localparam logic [3:0] S_ADDR_HI = 4'd4;
  localparam logic [3:0] S_END_A   = 4'd5;
  localparam logic [3:0] S_START_R = 4'd6;
  localparam logic [3:0] S_RECV_HI = 4'd7;
  localparam logic [3:0] S_RECV_LO = 4'd8;
  localparam logic [3:0] S_DATA_LO = 4'd9;
  localparam logic [3:0] S_DATA_HI = 4'd10;
  localparam logic [3:0] S_END     = 4'd11;
  localparam logic [3:0] S_RESP    = 4'd12;

  logic [3:0] state_q, state_d;
  logic       emits;
  logic [3:0] after_st;

  assign in_ready_o = (state_q == S_IDLE);

  // state that follows once the current beat leaves
  always_comb begin
    cmd_o.accept  = in_valid_i && in_ready_o;
    after_st      = S_IDLE;
    cmd_o.step    = i2cam_pkg::STEP_RESP;
    emits         = 1'b1;
    case (state_q)
      S_IDLE: begin
        emits    = 1'b0;
        after_st = S_IDLE;
      end
      S_DECODE: begin
        emits    = 1'b0;
        after_st = sts_i.xfer ? S_START_W : S_RESP;
      end
      S_START_W: begin
        cmd_o.step = i2cam_pkg::STEP_START_W;
        after_st   = sts_i.wr_refused ? S_RESP : S_ADDR_LO;
      end
      S_ADDR_LO: begin
        cmd_o.step = i2cam_pkg::STEP_ADDR_LO;
        after_st   = sts_i.addr16 ? S_ADDR_HI : (sts_i.is_read ? S_END_A : S_DATA_LO);
      end
      S_ADDR_HI: begin
        cmd_o.step = i2cam_pkg::STEP_ADDR_HI;
        after_st   = sts_i.is_read ? S_END_A : S_DATA_LO;
      end
      S_END_A: begin
        cmd_o.step = i2cam_pkg::STEP_END;
        after_st   = S_START_R;
      end
      S_START_R: begin
        cmd_o.step = i2cam_pkg::STEP_START_R;
        after_st   = sts_i.rd_refused ? S_RESP : S_RECV_HI;
      end
      S_RECV_HI: begin
        cmd_o.step = i2cam_pkg::STEP_RECV_HI;
        after_st   = sts_i.data16 ? S_RECV_LO : S_END;
      end
      S_RECV_LO: begin
        cmd_o.step = i2cam_pkg::STEP_RECV_LO;
        after_st   = S_END;
      end
      S_DATA_LO: begin
        cmd_o.step = i2cam_pkg::STEP_DATA_LO;
        after_st   = sts_i.data16 ? S_DATA_HI : S_END;
      end
      S_DATA_HI: begin
        cmd_o.step = i2cam_pkg::STEP_DATA_HI;
        after_st   = S_END;
      end
      S_END: begin
        cmd_o.step = i2cam_pkg::STEP_END;
        after_st   = S_RESP;
      end
      S_RESP: begin
        cmd_o.step = i2cam_pkg::STEP_RESP;
        after_st   = S_IDLE;
      end
      default: begin
        emits    = 1'b0;
        after_st = S_IDLE;
      end
    endcase
    cmd_o.fire = emits && sts_i.emit_ok;
  end

  always_comb begin
    state_d = state_q;
    if (cmd_o.accept) begin
      state_d = S_DECODE;
    end else if (!emits || sts_i.emit_ok) begin
      if (state_q != S_IDLE) begin
        state_d = after_st;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == S_DECODE)
    else $error("accepted access did not enter decode");

  a_fire_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fire |-> sts_i.emit_ok)
    else $error("beat issued while output register full");

  a_resp_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fire && state_q == S_RESP |=> state_q == S_IDLE)
    else $error("response beat did not return to idle");

endmodule

[sv/i2cam_dp.sv]
// datapath for the auto-mode i2c master: register file, latched access,
// beat composition and the output register
// depends on i2cam_pkg
module i2cam_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2cam_pkg::in_item_t   in_data_i,
  input  i2cam_pkg::dp_cmd_t    cmd_i,
  output i2cam_pkg::dp_sts_t    sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output i2cam_pkg::out_item_t  out_data_o
);

  i2cam_pkg::in_item_t  item_q;
  i2cam_pkg::out_item_t out_q, beat;
  logic                 out_valid_q, out_valid_d;

  logic [31:0] ctrl_q, ctrl_d;
  logic [9:0]  tar_q, tar_d;
  logic [31:0] auto_q, auto_d;
  logic [31:0] scl_hi_q, scl_hi_d;
  logic [31:0] scl_lo_q, scl_lo_d;
  logic        abort_q, abort_d;
  logic [31:0] mask_q, mask_d;
  logic [7:0]  rx_tl_q, rx_tl_d;
  logic [7:0]  tx_tl_q, tx_tl_d;
  logic [31:0] sda_hold_q, sda_hold_d;
  logic        enable_q, enable_d;
  logic        unlock_q, unlock_d;
  logic [15:0] rx_word_q, rx_word_d;
  logic        rx_valid_q, rx_valid_d;
  logic [31:0] rd_mux;
  logic        resp_fire;

  assign sts_o.emit_ok    = !out_valid_q || out_ready_i;
  assign sts_o.xfer       = (item_q.cmd == i2cam_pkg::CMD_WRITE)
                            && (item_q.offset == i2cam_pkg::OFF_XFER)
                            && enable_q && auto_q[31];
  assign sts_o.is_read    = auto_q[30];
  assign sts_o.addr16     = auto_q[29];
  assign sts_o.data16     = auto_q[28];
  assign sts_o.wr_refused = item_q.write_start_refused;
  assign sts_o.rd_refused = item_q.read_start_refused;

  // register read view
  always_comb begin
    rd_mux = '0;
    case (item_q.offset)
      i2cam_pkg::OFF_CTRL:     rd_mux = ctrl_q;
      i2cam_pkg::OFF_TAR:      rd_mux = 32'(tar_q);
      i2cam_pkg::OFF_SCL_HI:   rd_mux = scl_hi_q;
      i2cam_pkg::OFF_SCL_LO:   rd_mux = scl_lo_q;
      i2cam_pkg::OFF_INTR_ST:  rd_mux[i2cam_pkg::ABORT_BIT] =
                                 abort_q && !mask_q[i2cam_pkg::ABORT_BIT];
      i2cam_pkg::OFF_INTR_MSK: rd_mux = mask_q;
      i2cam_pkg::OFF_RAW_ST:   rd_mux[i2cam_pkg::ABORT_BIT] = abort_q;
      i2cam_pkg::OFF_RX_TL:    rd_mux = 32'(rx_tl_q);
      i2cam_pkg::OFF_TX_TL:    rd_mux = 32'(tx_tl_q);
      i2cam_pkg::OFF_ENABLE:   rd_mux = 32'(enable_q);
      i2cam_pkg::OFF_RXFLR:    rd_mux = 32'(rx_valid_q);
      i2cam_pkg::OFF_SDA_HOLD: rd_mux = sda_hold_q;
      i2cam_pkg::OFF_EN_ST:    rd_mux = 32'(enable_q);
      i2cam_pkg::OFF_LOCK:     rd_mux = 32'(unlock_q);
      i2cam_pkg::OFF_AUTO: begin
        rd_mux = auto_q | i2cam_pkg::AUTO_RD_BITS;
        rd_mux[i2cam_pkg::AUTO_RXV_BIT]   = rd_mux[i2cam_pkg::AUTO_RXV_BIT] | rx_valid_q;
        rd_mux[i2cam_pkg::AUTO_ABORT_BIT] = rd_mux[i2cam_pkg::AUTO_ABORT_BIT] | abort_q;
      end
      i2cam_pkg::OFF_XFER:     rd_mux = rx_valid_q ? 32'(rx_word_q) : '0;
      default:                 rd_mux = '0;
    endcase
  end

  assign resp_fire = cmd_i.fire && (cmd_i.step == i2cam_pkg::STEP_RESP);

  // register updates
  always_comb begin
    ctrl_d     = ctrl_q;
    tar_d      = tar_q;
    auto_d     = auto_q;
    scl_hi_d   = scl_hi_q;
    scl_lo_d   = scl_lo_q;
    abort_d    = abort_q;
    mask_d     = mask_q;
    rx_tl_d    = rx_tl_q;
    tx_tl_d    = tx_tl_q;
    sda_hold_d = sda_hold_q;
    enable_d   = enable_q;
    unlock_d   = unlock_q;
    rx_word_d  = rx_word_q;
    rx_valid_d = rx_valid_q;
    if (cmd_i.fire) begin
      case (cmd_i.step)
        i2cam_pkg::STEP_START_W: begin
          if (item_q.write_start_refused) begin
            abort_d = 1'b1;
          end
        end
        i2cam_pkg::STEP_START_R: begin
          if (item_q.read_start_refused) begin
            abort_d    = 1'b1;
            rx_word_d  = i2cam_pkg::RX_REFUSED;
            rx_valid_d = 1'b1;
          end
        end
        i2cam_pkg::STEP_RECV_HI: begin
          rx_word_d  = auto_q[28] ? {item_q.recv_first, item_q.recv_second}
                                  : {8'h00, item_q.recv_first};
          rx_valid_d = 1'b1;
        end
        default: ;
      endcase
    end
    if (resp_fire && item_q.cmd == i2cam_pkg::CMD_READ
        && item_q.offset == i2cam_pkg::OFF_XFER) begin
      rx_valid_d = 1'b0;
    end
    if (resp_fire && item_q.cmd == i2cam_pkg::CMD_WRITE) begin
      case (item_q.offset)
        i2cam_pkg::OFF_LOCK:     unlock_d   = (item_q.wdata == i2cam_pkg::UNLOCK_KEY);
        i2cam_pkg::OFF_CTRL:     ctrl_d     = item_q.wdata;
        i2cam_pkg::OFF_TAR:      tar_d      = item_q.wdata[9:0];
        i2cam_pkg::OFF_SCL_HI:   scl_hi_d   = item_q.wdata;
        i2cam_pkg::OFF_SCL_LO:   scl_lo_d   = item_q.wdata;
        i2cam_pkg::OFF_INTR_MSK: mask_d     = item_q.wdata;
        i2cam_pkg::OFF_RX_TL:    rx_tl_d    = item_q.wdata[7:0];
        i2cam_pkg::OFF_TX_TL:    tx_tl_d    = item_q.wdata[7:0];
        i2cam_pkg::OFF_CLR_INTR: abort_d    = 1'b0;
        i2cam_pkg::OFF_ENABLE:   enable_d   = item_q.wdata[0];
        i2cam_pkg::OFF_SDA_HOLD: sda_hold_d = item_q.wdata;
        i2cam_pkg::OFF_AUTO: begin
          auto_d = item_q.wdata;
          if (item_q.wdata[31:24] == i2cam_pkg::AUTO_OFF_TOP) begin
            abort_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // beat composition
  always_comb begin
    beat      = '0;
    beat.kind = i2cam_pkg::KIND_BUS;
    case (cmd_i.step)
      i2cam_pkg::STEP_START_W: begin
        beat.bus_op    = i2cam_pkg::OP_START_W;
        beat.bus_slave = tar_q[6:0];
      end
      i2cam_pkg::STEP_ADDR_LO: begin
        beat.bus_op   = i2cam_pkg::OP_SEND;
        beat.bus_byte = item_q.wdata[23:16];
      end
      i2cam_pkg::STEP_ADDR_HI: begin
        beat.bus_op   = i2cam_pkg::OP_SEND;
        beat.bus_byte = item_q.wdata[31:24];
      end
      i2cam_pkg::STEP_END: beat.bus_op = i2cam_pkg::OP_END;
      i2cam_pkg::STEP_START_R: begin
        beat.bus_op    = i2cam_pkg::OP_START_R;
        beat.bus_slave = tar_q[6:0];
      end
      i2cam_pkg::STEP_RECV_HI: begin
        beat.bus_op   = i2cam_pkg::OP_RECV;
        beat.bus_byte = item_q.recv_first;
      end
      i2cam_pkg::STEP_RECV_LO: begin
        beat.bus_op   = i2cam_pkg::OP_RECV;
        beat.bus_byte = item_q.recv_second;
      end
      i2cam_pkg::STEP_DATA_LO: begin
        beat.bus_op   = i2cam_pkg::OP_SEND;
        beat.bus_byte = item_q.wdata[7:0];
      end
      i2cam_pkg::STEP_DATA_HI: begin
        beat.bus_op   = i2cam_pkg::OP_SEND;
        beat.bus_byte = item_q.wdata[15:8];
      end
      i2cam_pkg::STEP_RESP: begin
        beat.kind      = i2cam_pkg::KIND_RESP;
        beat.last      = 1'b1;
        beat.read_data = (item_q.cmd == i2cam_pkg::CMD_READ) ? rd_mux : '0;
      end
      default: ;
    endcase
    beat.irq = abort_d && !mask_d[i2cam_pkg::ABORT_BIT];
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.fire) begin
      out_q <= beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ctrl_q      <= '0;
      tar_q       <= '0;
      auto_q      <= i2cam_pkg::AUTO_RESET;
      scl_hi_q    <= '0;
      scl_lo_q    <= '0;
      abort_q     <= 1'b0;
      mask_q      <= '0;
      rx_tl_q     <= '0;
      tx_tl_q     <= '0;
      sda_hold_q  <= '0;
      enable_q    <= 1'b0;
      unlock_q    <= 1'b0;
      rx_word_q   <= '0;
      rx_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      ctrl_q      <= ctrl_d;
      tar_q       <= tar_d;
      auto_q      <= auto_d;
      scl_hi_q    <= scl_hi_d;
      scl_lo_q    <= scl_lo_d;
      abort_q     <= abort_d;
      mask_q      <= mask_d;
      rx_tl_q     <= rx_tl_d;
      tx_tl_q     <= tx_tl_d;
      sda_hold_q  <= sda_hold_d;
      enable_q    <= enable_d;
      unlock_q    <= unlock_d;
      rx_word_q   <= rx_word_d;
      rx_valid_q  <= rx_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_last_on_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.last == (out_q.kind == i2cam_pkg::KIND_RESP))
    else $error("last flag does not match response beat");

  a_bus_no_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == i2cam_pkg::KIND_BUS |-> out_q.read_data == '0)
    else $error("bus operation beat carries read data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("output beat changed while stalled");

endmodule

[sv/i2c_auto_mode_controller.sv]
// top level of the auto-mode i2c master: sequencer plus datapath
// depends on i2cam_pkg, i2cam_ctrl, i2cam_dp
//
// Each input beat is one 32-bit register access. A write to the transfer
// register (0x0B4) with the block enabled and auto mode armed produces the
// bus operation beats of the transfer, then one response beat with last set;
// every other access gives the response beat alone. The sequencer passes
// through a decode state and then one state per result beat, and waits in
// its state while the output is stalled; it issues one beat per cycle through
// a single output register while the output is not stalled, and takes the
// next access once the response beat has been issued.
module i2c_auto_mode_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  i2cam_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output i2cam_pkg::out_item_t  out_data_o
);

  i2cam_pkg::dp_cmd_t cmd;
  i2cam_pkg::dp_sts_t sts;

  i2cam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  i2cam_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
